// File: hw/rtl/pldlt_pkg.sv
// ============================================================================
// pldlt_pkg
// Shared widths, codes and fixed-point helpers for the permuted LDL^T solver.
// ============================================================================
package pldlt_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int QUOT_W  = VALUE_W + FRAC_W;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 14;
    localparam int ROW_W   = 10;
    localparam int PTR_W   = 15;
    localparam int DIM_W   = 11;
    localparam int STAT_W  = 2;

    localparam int DEF_MAX_DIM = 1024;
    localparam int DEF_MAX_NNZ = 16384;

    localparam int IDX_LSB = 0;
    localparam int ROW_LSB = IDX_LSB + IDX_W;
    localparam int PTR_LSB = ROW_LSB + ROW_W;
    localparam int VAL_LSB = PTR_LSB + PTR_W;
    localparam int IN_DATA_W  = ((VAL_LSB + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + STAT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_COL_START = 3'd0,
        OP_L_ENTRY   = 3'd1,
        OP_D_DIAG    = 3'd2,
        OP_D_SUB     = 3'd3,
        OP_PERM      = 3'd4,
        OP_RHS       = 3'd5,
        OP_SOLVE     = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    typedef logic signed [VALUE_W-1:0] fx_t;

    localparam fx_t FX_MAX = fx_t'({1'b0, {(VALUE_W-1){1'b1}}});
    localparam fx_t FX_MIN = fx_t'({1'b1, {(VALUE_W-1){1'b0}}});

    typedef struct packed {
        fx_t  val;
        logic ovf;
    } fx_res_t;

    function automatic logic [VALUE_W-1:0] mag_fn(input fx_t a);
        logic [VALUE_W-1:0] u;
        u = a;
        return a[VALUE_W-1] ? (~u + VALUE_W'(1)) : u;
    endfunction

    // Signed magnitude to a saturated value; the negative limit is one larger.
    function automatic fx_res_t from_mag_fn(input logic [QUOT_W-1:0] m, input logic neg);
        logic [QUOT_W-1:0] lim;
        logic [QUOT_W-1:0] mm;
        fx_res_t r;
        lim = neg ? (QUOT_W'(1) << (VALUE_W - 1))
                  : ((QUOT_W'(1) << (VALUE_W - 1)) - QUOT_W'(1));
        r.ovf = (m > lim);
        mm = r.ovf ? lim : m;
        r.val = neg ? fx_t'(-mm[VALUE_W-1:0]) : fx_t'(mm[VALUE_W-1:0]);
        return r;
    endfunction

    function automatic fx_res_t sub_fn(input fx_t a, input fx_t b);
        logic signed [VALUE_W:0] d;
        fx_res_t r;
        d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
        r.ovf = (d[VALUE_W] != d[VALUE_W-1]);
        r.val = r.ovf ? (d[VALUE_W] ? FX_MIN : FX_MAX) : fx_t'(d[VALUE_W-1:0]);
        return r;
    endfunction

endpackage

// File: hw/rtl/pldlt_ram.sv
// ============================================================================
// pldlt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module pldlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/permuted_ldlt_block_solve_unit.sv
// ============================================================================
// permuted_ldlt_block_solve_unit
// Loads sparse LDL^T factors and solves L D L^T (P x) = P b in Q16.16.
// ============================================================================
// Load words (column starts, L entries, D diagonal and sub-diagonal, permutation,
// right-hand side) are taken one per cycle while the unit is idle. A read word
// waits on the registered read port of the right-hand-side store before its
// result is sent. A solve holds the input off for its whole run: the gather, the
// forward pass, the D pass (a 2x2 block costs six multiplies and two divisions),
// the backward pass and the scatter. The time is set by the single shared
// multiplier, the one-bit-per-cycle divider and the single read port of each
// factor memory. The memories hold no reset value; every entry must be loaded
// before a solve or read uses it.
module permuted_ldlt_block_solve_unit
    import pldlt_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int MAX_NNZ = DEF_MAX_NNZ
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // index[13:0], row[23:14], pointer[38:24], value[70:39], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // value_res[31:0], status[33:32], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int DIM_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_CW = $clog2(MAX_DIM + 1);
    localparam int CS_AW  = $clog2(MAX_DIM + 1);
    localparam int NNZ_AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int EP_W   = (MAX_NNZ > 1) ? $clog2(MAX_NNZ + 1) : 1;
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam int ENT_W  = ROW_W + VALUE_W;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RD_WAIT, ST_DONE,
        ST_G_PERM, ST_G_RHS, ST_G_WR,
        ST_F_COL, ST_F_COL2, ST_F_COL3, ST_F_ENT, ST_F_ENT2, ST_F_ENT3, ST_F_ENT4,
        ST_D_TOP, ST_D_CHK, ST_D1_WR, ST_D2_LD, ST_D2_P1, ST_D2_DET, ST_D2_P2,
        ST_D2_Q0, ST_D2_W0, ST_D2_P3, ST_D2_Q1, ST_D2_W1,
        ST_B_COL, ST_B_COL2, ST_B_COL3, ST_B_ENT, ST_B_ENT2, ST_B_ENT3, ST_B_ENT4,
        ST_S_PERM, ST_S_WR,
        ST_M_MUL, ST_M_SAT, ST_M_SUB,
        ST_V_START, ST_V_STEP, ST_V_END
    } state_t;

    function automatic logic [EP_W-1:0] ptr_sat(input logic [PTR_W-1:0] p);
        return (32'(p) > 32'(MAX_NNZ)) ? EP_W'(MAX_NNZ) : EP_W'(p);
    endfunction

    // Input fields
    logic [IDX_W-1:0] in_index;
    logic [ROW_W-1:0] in_row;
    logic [PTR_W-1:0] in_pointer;
    fx_t              in_value;
    op_t              in_op;
    logic             in_acc;
    logic             idx_dim_ok;
    logic             idx_cs_ok;
    logic             idx_nnz_ok;

    assign in_index   = s_axis_tdata[IDX_LSB +: IDX_W];
    assign in_row     = s_axis_tdata[ROW_LSB +: ROW_W];
    assign in_pointer = s_axis_tdata[PTR_LSB +: PTR_W];
    assign in_value   = s_axis_tdata[VAL_LSB +: VALUE_W];
    assign in_op      = op_t'(s_axis_tuser);
    assign idx_dim_ok = 32'(in_index) < 32'(MAX_DIM);
    assign idx_cs_ok  = 32'(in_index) <= 32'(MAX_DIM);
    assign idx_nnz_ok = 32'(in_index) < 32'(MAX_NNZ);

    // Registers
    state_t               state_reg;
    state_t               ret_reg;
    logic [DIM_W-1:0]     dim_reg;
    logic [DIM_CW-1:0]    i_reg;
    logic [EP_W-1:0]      j_reg;
    logic [EP_W-1:0]      end_reg;
    logic [ROW_W-1:0]     s_reg;
    logic [ROW_W-1:0]     r_reg;
    fx_t                  v_reg;
    fx_t                  ev_reg;
    fx_t                  a_reg;
    fx_t                  b_reg;
    fx_t                  x_reg;
    fx_t                  res_reg;
    fx_t                  da_reg;
    fx_t                  db_reg;
    fx_t                  dd_reg;
    fx_t                  y0_reg;
    fx_t                  y1_reg;
    fx_t                  det_reg;
    fx_t                  num_reg;
    fx_t                  den_reg;
    logic                 sub_mode_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 pneg_reg;
    logic [QUOT_W-1:0]    dvd_reg;
    logic [VALUE_W-1:0]   ud_reg;
    logic [VALUE_W-1:0]   rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 dneg_reg;
    logic                 sat_reg;
    logic                 zero_reg;
    logic                 rd_ok_reg;
    logic                 out_valid_reg;
    fx_t                  out_value_reg;
    logic [STAT_W-1:0]    out_status_reg;

    logic [DIM_CW-1:0]    n_cur;
    assign n_cur = (32'(dim_reg) > 32'(MAX_DIM)) ? DIM_CW'(MAX_DIM) : DIM_CW'(dim_reg);

    // Memory ports
    logic [CS_AW-1:0]   cs_raddr;
    logic [PTR_W-1:0]   cs_rdata;
    logic [NNZ_AW-1:0]  ent_raddr;
    logic [ENT_W-1:0]   ent_rdata;
    logic [DIM_AW-1:0]  dm_raddr;
    logic [VALUE_W-1:0] dm_rdata;
    logic [DIM_AW-1:0]  do_raddr;
    logic [VALUE_W-1:0] do_rdata;
    logic [DIM_AW-1:0]  pm_raddr;
    logic [ROW_W-1:0]   pm_rdata;
    logic [DIM_AW-1:0]  rhs_raddr;
    logic [VALUE_W-1:0] rhs_rdata;
    logic               rhs_we;
    logic [DIM_AW-1:0]  rhs_waddr;
    logic [VALUE_W-1:0] rhs_wdata;
    logic [DIM_AW-1:0]  wk_raddr;
    logic [VALUE_W-1:0] wk_rdata;
    logic               wk_we;
    logic [DIM_AW-1:0]  wk_waddr;
    logic [VALUE_W-1:0] wk_wdata;

    logic [ROW_W-1:0]   ent_row;
    fx_t                ent_val;
    assign ent_row = ent_rdata[ENT_W-1:VALUE_W];
    assign ent_val = ent_rdata[VALUE_W-1:0];

    logic load_ok;
    assign load_ok = in_acc && (state_reg == ST_IDLE);

    pldlt_ram #(.WIDTH(PTR_W), .DEPTH(MAX_DIM + 1)) u_cs_ram (
        .clk(clk), .we(load_ok && (in_op == OP_COL_START) && idx_cs_ok),
        .waddr(CS_AW'(in_index)), .wdata(in_pointer), .raddr(cs_raddr), .rdata(cs_rdata)
    );
    pldlt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_ent_ram (
        .clk(clk), .we(load_ok && (in_op == OP_L_ENTRY) && idx_nnz_ok),
        .waddr(NNZ_AW'(in_index)), .wdata({in_row, in_value}),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );
    pldlt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_dm_ram (
        .clk(clk), .we(load_ok && (in_op == OP_D_DIAG) && idx_dim_ok),
        .waddr(DIM_AW'(in_index)), .wdata(in_value), .raddr(dm_raddr), .rdata(dm_rdata)
    );
    pldlt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_do_ram (
        .clk(clk), .we(load_ok && (in_op == OP_D_SUB) && idx_dim_ok),
        .waddr(DIM_AW'(in_index)), .wdata(in_value), .raddr(do_raddr), .rdata(do_rdata)
    );
    pldlt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_DIM)) u_pm_ram (
        .clk(clk), .we(load_ok && (in_op == OP_PERM) && idx_dim_ok),
        .waddr(DIM_AW'(in_index)), .wdata(in_row), .raddr(pm_raddr), .rdata(pm_rdata)
    );
    pldlt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_rhs_ram (
        .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata),
        .raddr(rhs_raddr), .rdata(rhs_rdata)
    );
    pldlt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_wk_ram (
        .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata)
    );

    // Memory address and write selection by sequencer state.
    always_comb
    begin
        wk_raddr  = DIM_AW'(i_reg);
        wk_we     = 1'b0;
        wk_waddr  = DIM_AW'(i_reg);
        wk_wdata  = res_reg;
        cs_raddr  = CS_AW'(i_reg);
        ent_raddr = NNZ_AW'(j_reg);
        dm_raddr  = DIM_AW'(i_reg);
        do_raddr  = DIM_AW'(i_reg);
        pm_raddr  = DIM_AW'(i_reg);
        rhs_raddr = DIM_AW'(s_reg);
        rhs_we    = 1'b0;
        rhs_waddr = DIM_AW'(in_index);
        rhs_wdata = in_value;
        unique case (state_reg)
            ST_IDLE:
            begin
                rhs_raddr = DIM_AW'(in_index);
                rhs_we    = in_acc && (in_op == OP_RHS) && idx_dim_ok;
            end
            ST_G_RHS:
            begin
                rhs_raddr = DIM_AW'(pm_rdata);
            end
            ST_G_WR:
            begin
                wk_we    = 1'b1;
                wk_wdata = (32'(s_reg) < 32'(n_cur)) ? rhs_rdata : '0;
            end
            ST_F_COL2, ST_B_COL2:
            begin
                cs_raddr = CS_AW'(i_reg + DIM_CW'(1));
            end
            ST_F_ENT2, ST_B_ENT2:
            begin
                wk_raddr = DIM_AW'(ent_row);
            end
            ST_F_ENT4:
            begin
                wk_we    = 1'b1;
                wk_waddr = DIM_AW'(r_reg);
            end
            ST_D_CHK:
            begin
                dm_raddr = DIM_AW'(i_reg + DIM_CW'(1));
                wk_raddr = DIM_AW'(i_reg + DIM_CW'(1));
            end
            ST_D1_WR, ST_D2_W0:
            begin
                wk_we = 1'b1;
            end
            ST_D2_W1:
            begin
                wk_we    = 1'b1;
                wk_waddr = DIM_AW'(i_reg + DIM_CW'(1));
            end
            ST_B_ENT:
            begin
                wk_we    = (j_reg >= end_reg);
                wk_wdata = v_reg;
            end
            ST_S_WR:
            begin
                rhs_we    = 32'(pm_rdata) < 32'(n_cur);
                rhs_waddr = DIM_AW'(pm_rdata);
                rhs_wdata = wk_rdata;
            end
            default:
            begin
            end
        endcase
    end

    // Shared arithmetic datapath
    logic [PROD_W-1:0]  prod_c;
    fx_res_t            prod_sat;
    fx_res_t            diff_c;
    fx_res_t            quot_sat;
    logic [VALUE_W:0]   div_sh;
    logic               div_ge;
    logic [VALUE_W-1:0] div_rem_next;

    assign prod_c       = mag_fn(a_reg) * mag_fn(b_reg);
    assign prod_sat     = from_mag_fn(prod_reg[PROD_W-1:FRAC_W], pneg_reg);
    assign diff_c       = sub_fn(x_reg, res_reg);
    assign quot_sat     = from_mag_fn(dvd_reg, dneg_reg);
    assign div_sh       = {rem_reg, dvd_reg[QUOT_W-1]};
    assign div_ge       = div_sh >= {1'b0, ud_reg};
    assign div_rem_next = div_ge ? VALUE_W'(div_sh - {1'b0, ud_reg}) : div_sh[VALUE_W-1:0];

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - STAT_W){1'b0}},
                            out_status_reg, out_value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            dim_reg        <= DIM_W'(1);
            i_reg          <= '0;
            j_reg          <= '0;
            end_reg        <= '0;
            s_reg          <= '0;
            r_reg          <= '0;
            v_reg          <= '0;
            ev_reg         <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            x_reg          <= '0;
            res_reg        <= '0;
            da_reg         <= '0;
            db_reg         <= '0;
            dd_reg         <= '0;
            y0_reg         <= '0;
            y1_reg         <= '0;
            det_reg        <= '0;
            num_reg        <= '0;
            den_reg        <= '0;
            sub_mode_reg   <= 1'b0;
            prod_reg       <= '0;
            pneg_reg       <= 1'b0;
            dvd_reg        <= '0;
            ud_reg         <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            dneg_reg       <= 1'b0;
            sat_reg        <= 1'b0;
            zero_reg       <= 1'b0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dim_reg <= cfg_data;
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (in_op == OP_SOLVE))
                    begin
                        sat_reg   <= 1'b0;
                        zero_reg  <= 1'b0;
                        i_reg     <= '0;
                        v_reg     <= '0;
                        state_reg <= (n_cur == '0) ? ST_DONE : ST_G_PERM;
                    end
                    else if (in_acc && (in_op == OP_READ))
                    begin
                        sat_reg   <= 1'b0;
                        zero_reg  <= 1'b0;
                        rd_ok_reg <= idx_dim_ok;
                        state_reg <= ST_RD_WAIT;
                    end
                end
                ST_RD_WAIT:
                begin
                    v_reg     <= rd_ok_reg ? fx_t'(rhs_rdata) : '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= v_reg;
                        out_status_reg <= zero_reg ? STAT_ZERO : (sat_reg ? STAT_SAT : STAT_OK);
                        state_reg      <= ST_IDLE;
                    end
                end

                // Gather through the permutation.
                ST_G_PERM:
                begin
                    state_reg <= ST_G_RHS;
                end
                ST_G_RHS:
                begin
                    s_reg     <= pm_rdata;
                    state_reg <= ST_G_WR;
                end
                ST_G_WR:
                begin
                    if ((i_reg + DIM_CW'(1)) == n_cur)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_F_COL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + DIM_CW'(1);
                        state_reg <= ST_G_PERM;
                    end
                end

                // Forward solve, one column at a time.
                ST_F_COL:
                begin
                    state_reg <= ST_F_COL2;
                end
                ST_F_COL2:
                begin
                    v_reg     <= wk_rdata;
                    j_reg     <= ptr_sat(cs_rdata);
                    state_reg <= ST_F_COL3;
                end
                ST_F_COL3:
                begin
                    end_reg   <= ptr_sat(cs_rdata);
                    state_reg <= ST_F_ENT;
                end
                ST_F_ENT:
                begin
                    if (j_reg >= end_reg)
                    begin
                        if ((i_reg + DIM_CW'(1)) == n_cur)
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_D_TOP;
                        end
                        else
                        begin
                            i_reg     <= i_reg + DIM_CW'(1);
                            state_reg <= ST_F_COL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_F_ENT2;
                    end
                end
                ST_F_ENT2:
                begin
                    r_reg  <= ent_row;
                    ev_reg <= ent_val;
                    if (32'(ent_row) < 32'(n_cur))
                    begin
                        state_reg <= ST_F_ENT3;
                    end
                    else
                    begin
                        j_reg     <= j_reg + EP_W'(1);
                        state_reg <= ST_F_ENT;
                    end
                end
                ST_F_ENT3:
                begin
                    x_reg        <= wk_rdata;
                    a_reg        <= ev_reg;
                    b_reg        <= v_reg;
                    sub_mode_reg <= 1'b1;
                    ret_reg      <= ST_F_ENT4;
                    state_reg    <= ST_M_MUL;
                end
                ST_F_ENT4:
                begin
                    j_reg     <= j_reg + EP_W'(1);
                    state_reg <= ST_F_ENT;
                end

                // Block-diagonal solve.
                ST_D_TOP:
                begin
                    state_reg <= ST_D_CHK;
                end
                ST_D_CHK:
                begin
                    da_reg <= dm_rdata;
                    y0_reg <= wk_rdata;
                    if (((i_reg + DIM_CW'(1)) < n_cur) && (do_rdata != '0))
                    begin
                        db_reg    <= do_rdata;
                        state_reg <= ST_D2_LD;
                    end
                    else
                    begin
                        num_reg   <= wk_rdata;
                        den_reg   <= dm_rdata;
                        ret_reg   <= ST_D1_WR;
                        state_reg <= ST_V_START;
                    end
                end
                ST_D1_WR:
                begin
                    if ((i_reg + DIM_CW'(1)) == n_cur)
                    begin
                        state_reg <= ST_B_COL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + DIM_CW'(1);
                        state_reg <= ST_D_TOP;
                    end
                end
                ST_D2_LD:
                begin
                    dd_reg       <= dm_rdata;
                    y1_reg       <= wk_rdata;
                    a_reg        <= da_reg;
                    b_reg        <= dm_rdata;
                    sub_mode_reg <= 1'b0;
                    ret_reg      <= ST_D2_P1;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_P1:
                begin
                    x_reg        <= res_reg;
                    a_reg        <= db_reg;
                    b_reg        <= db_reg;
                    sub_mode_reg <= 1'b1;
                    ret_reg      <= ST_D2_DET;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_DET:
                begin
                    det_reg      <= res_reg;
                    a_reg        <= dd_reg;
                    b_reg        <= y0_reg;
                    sub_mode_reg <= 1'b0;
                    ret_reg      <= ST_D2_P2;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_P2:
                begin
                    x_reg        <= res_reg;
                    a_reg        <= db_reg;
                    b_reg        <= y1_reg;
                    sub_mode_reg <= 1'b1;
                    ret_reg      <= ST_D2_Q0;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_Q0:
                begin
                    num_reg   <= res_reg;
                    den_reg   <= det_reg;
                    ret_reg   <= ST_D2_W0;
                    state_reg <= ST_V_START;
                end
                ST_D2_W0:
                begin
                    a_reg        <= da_reg;
                    b_reg        <= y1_reg;
                    sub_mode_reg <= 1'b0;
                    ret_reg      <= ST_D2_P3;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_P3:
                begin
                    x_reg        <= res_reg;
                    a_reg        <= db_reg;
                    b_reg        <= y0_reg;
                    sub_mode_reg <= 1'b1;
                    ret_reg      <= ST_D2_Q1;
                    state_reg    <= ST_M_MUL;
                end
                ST_D2_Q1:
                begin
                    num_reg   <= res_reg;
                    den_reg   <= det_reg;
                    ret_reg   <= ST_D2_W1;
                    state_reg <= ST_V_START;
                end
                ST_D2_W1:
                begin
                    if ((i_reg + DIM_CW'(2)) >= n_cur)
                    begin
                        i_reg     <= i_reg + DIM_CW'(1);
                        state_reg <= ST_B_COL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + DIM_CW'(2);
                        state_reg <= ST_D_TOP;
                    end
                end

                // Backward solve with L transposed, last column first.
                ST_B_COL:
                begin
                    state_reg <= ST_B_COL2;
                end
                ST_B_COL2:
                begin
                    v_reg     <= wk_rdata;
                    j_reg     <= ptr_sat(cs_rdata);
                    state_reg <= ST_B_COL3;
                end
                ST_B_COL3:
                begin
                    end_reg   <= ptr_sat(cs_rdata);
                    state_reg <= ST_B_ENT;
                end
                ST_B_ENT:
                begin
                    if (j_reg >= end_reg)
                    begin
                        if (i_reg == '0)
                        begin
                            state_reg <= ST_S_PERM;
                        end
                        else
                        begin
                            i_reg     <= i_reg - DIM_CW'(1);
                            state_reg <= ST_B_COL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_B_ENT2;
                    end
                end
                ST_B_ENT2:
                begin
                    ev_reg <= ent_val;
                    if (32'(ent_row) < 32'(n_cur))
                    begin
                        state_reg <= ST_B_ENT3;
                    end
                    else
                    begin
                        j_reg     <= j_reg + EP_W'(1);
                        state_reg <= ST_B_ENT;
                    end
                end
                ST_B_ENT3:
                begin
                    x_reg        <= v_reg;
                    a_reg        <= ev_reg;
                    b_reg        <= wk_rdata;
                    sub_mode_reg <= 1'b1;
                    ret_reg      <= ST_B_ENT4;
                    state_reg    <= ST_M_MUL;
                end
                ST_B_ENT4:
                begin
                    v_reg     <= res_reg;
                    j_reg     <= j_reg + EP_W'(1);
                    state_reg <= ST_B_ENT;
                end

                // Scatter back through the permutation.
                ST_S_PERM:
                begin
                    state_reg <= ST_S_WR;
                end
                ST_S_WR:
                begin
                    if ((i_reg + DIM_CW'(1)) == n_cur)
                    begin
                        v_reg     <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + DIM_CW'(1);
                        state_reg <= ST_S_PERM;
                    end
                end

                // Multiply, optionally followed by x minus the product.
                ST_M_MUL:
                begin
                    prod_reg  <= prod_c;
                    pneg_reg  <= a_reg[VALUE_W-1] ^ b_reg[VALUE_W-1];
                    state_reg <= ST_M_SAT;
                end
                ST_M_SAT:
                begin
                    res_reg <= prod_sat.val;
                    if (prod_sat.ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= sub_mode_reg ? ST_M_SUB : ret_reg;
                end
                ST_M_SUB:
                begin
                    res_reg <= diff_c.val;
                    if (diff_c.ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= ret_reg;
                end

                // Restoring divider, one quotient bit per cycle.
                ST_V_START:
                begin
                    if (den_reg == '0)
                    begin
                        zero_reg <= 1'b1;
                        if (num_reg == '0)
                        begin
                            res_reg <= '0;
                        end
                        else
                        begin
                            res_reg <= num_reg[VALUE_W-1] ? FX_MIN : FX_MAX;
                        end
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        dvd_reg   <= {mag_fn(num_reg), {FRAC_W{1'b0}}};
                        ud_reg    <= mag_fn(den_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(QUOT_W - 1);
                        dneg_reg  <= num_reg[VALUE_W-1] ^ den_reg[VALUE_W-1];
                        state_reg <= ST_V_STEP;
                    end
                end
                ST_V_STEP:
                begin
                    rem_reg <= div_rem_next;
                    dvd_reg <= {dvd_reg[QUOT_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_V_END;
                    end
                end
                ST_V_END:
                begin
                    res_reg <= quot_sat.val;
                    if (quot_sat.ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= ret_reg;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_work_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wk_we)
        else $error("work vector written while idle");

    a_rhs_write_scatter: assert property (@(posedge clk) disable iff (!rst_n)
        (rhs_we && (state_reg != ST_IDLE)) |-> (state_reg == ST_S_WR))
        else $error("rhs store written outside the scatter");

    a_entry_in_column: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_F_ENT2) || (state_reg == ST_B_ENT2)) |-> (j_reg < end_reg))
        else $error("entry fetched past the column end");

    a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_V_STEP) && (cnt_reg == '0)) |=> (state_reg == ST_V_END))
        else $error("divider did not finish after its last step");

    a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ((in_op == OP_SOLVE) || (in_op == OP_READ))) |=> (state_reg != ST_IDLE))
        else $error("solve or read word accepted without starting");
`endif

endmodule

// File: tb/sv/tb_permuted_ldlt_block_solve_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_permuted_ldlt_block_solve_unit
// Self-checking bench for the permuted LDL^T block solver.
// ============================================================================
// A stimulus process builds load, solve and read words into a pending queue.
// A clocked driver sends them with random gaps. An internal fixed-point
// predictor applies each accepted word and queues the expected result words.
// A clocked monitor, with random back-pressure, checks each result word.
// Every store entry that a solve or read touches is loaded beforehand.
// ============================================================================
module tb_permuted_ldlt_block_solve_unit;
    import pldlt_pkg::*;

    localparam int     NDIM = 1024;
    localparam int     NNZ  = 16384;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        op_t         op;
        logic [13:0] idx;
        logic [9:0]  row;
        logic [14:0] ptr;
        logic [31:0] val;
    } word_t;

    typedef struct {
        logic [31:0] val;
        logic [1:0]  st;
    } result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DIM_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    permuted_ldlt_block_solve_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    int unsigned col_ptr_m[NDIM+1];
    int unsigned ent_row_m[NNZ];
    longint      ent_val_m[NNZ];
    longint      diag_m[NDIM];
    longint      subdiag_m[NDIM];
    int unsigned perm_m[NDIM];
    longint      rhs_m[NDIM];
    longint      work_m[NDIM];
    int          dim_m = 1;
    bit          hit_sat;
    bit          hit_zero;

    result_t     solution_q[$];
    word_t       pending_q[$];
    int          dim_req_q[$];
    word_t       cur_word;
    int          words_queued = 0;
    int          words_sent = 0;
    int          dim_writes = 0;
    int          dim_done = 0;
    int          errors = 0;
    int          gap = 0;
    int          stall = 0;
    int          gap_max = 8;
    int          stall_max = 8;

    function automatic longint clamp_fx(longint v);
        if (v > VMAX)
        begin
            hit_sat = 1'b1;
            return VMAX;
        end
        if (v < VMIN)
        begin
            hit_sat = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return clamp_fx(a - b);
    endfunction

    // The exact product fits in 64 bits; the shift truncates the magnitude.
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >> FRAC_W;
        return clamp_fx((p < 0) ? -m : m);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        if (den == 0)
        begin
            hit_zero = 1'b1;
            return (num > 0) ? VMAX : ((num < 0) ? VMIN : 0);
        end
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q  = (un << FRAC_W) / ud;
        return clamp_fx(((num < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic int unsigned col_bound(int c);
        return (col_ptr_m[c] > NNZ) ? NNZ : col_ptr_m[c];
    endfunction

    function automatic void factor_solve(int n);
        int unsigned s;
        int unsigned r;
        longint      v;
        longint      a;
        longint      b;
        longint      d;
        longint      det;
        longint      y0;
        longint      y1;
        int          i;
        for (i = 0; i < n; i++)
        begin
            s = perm_m[i];
            work_m[i] = (s < n) ? rhs_m[s] : 0;
        end
        for (i = 0; i < n; i++)
        begin
            v = work_m[i];
            for (int unsigned j = col_bound(i); j < col_bound(i + 1); j++)
            begin
                r = ent_row_m[j];
                if (r < n)
                    work_m[r] = fx_sub(work_m[r], fx_mul(ent_val_m[j], v));
            end
        end
        i = 0;
        while (i < n)
        begin
            if (i + 1 < n && subdiag_m[i] != 0)
            begin
                a   = diag_m[i];
                b   = subdiag_m[i];
                d   = diag_m[i + 1];
                det = fx_sub(fx_mul(a, d), fx_mul(b, b));
                y0  = work_m[i];
                y1  = work_m[i + 1];
                work_m[i]     = fx_div(fx_sub(fx_mul(d, y0), fx_mul(b, y1)), det);
                work_m[i + 1] = fx_div(fx_sub(fx_mul(a, y1), fx_mul(b, y0)), det);
                i += 2;
            end
            else
            begin
                work_m[i] = fx_div(work_m[i], diag_m[i]);
                i += 1;
            end
        end
        for (int c = n - 1; c >= 0; c--)
        begin
            v = work_m[c];
            for (int unsigned j = col_bound(c); j < col_bound(c + 1); j++)
            begin
                r = ent_row_m[j];
                if (r < n)
                    v = fx_sub(v, fx_mul(ent_val_m[j], work_m[r]));
            end
            work_m[c] = v;
        end
        for (i = 0; i < n; i++)
        begin
            s = perm_m[i];
            if (s < n)
                rhs_m[s] = work_m[i];
        end
    endfunction

    function automatic void absorb_word(word_t w);
        longint  v;
        result_t res;
        int      n;
        v = $signed(w.val);
        case (w.op)
            OP_COL_START: if (w.idx <= NDIM) col_ptr_m[w.idx] = w.ptr;
            OP_L_ENTRY:
            begin
                ent_row_m[w.idx] = w.row;
                ent_val_m[w.idx] = v;
            end
            OP_D_DIAG:    if (w.idx < NDIM) diag_m[w.idx] = v;
            OP_D_SUB:     if (w.idx < NDIM) subdiag_m[w.idx] = v;
            OP_PERM:      if (w.idx < NDIM) perm_m[w.idx] = w.row;
            OP_RHS:       if (w.idx < NDIM) rhs_m[w.idx] = v;
            OP_SOLVE:
            begin
                n = (dim_m > NDIM) ? NDIM : dim_m;
                hit_sat  = 1'b0;
                hit_zero = 1'b0;
                factor_solve(n);
                res.val = '0;
                res.st  = hit_zero ? STAT_ZERO : (hit_sat ? STAT_SAT : STAT_OK);
                solution_q.push_back(res);
            end
            default:
            begin
                res.val = (w.idx < NDIM) ? rhs_m[w.idx][31:0] : 32'd0;
                res.st  = STAT_OK;
                solution_q.push_back(res);
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver and configuration writer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid     <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_word(cur_word);
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    gap = gap - 1;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_word = pending_q.pop_front();
                    s_axis_tdata  <= IN_DATA_W'({cur_word.val, cur_word.ptr,
                                                 cur_word.row, cur_word.idx});
                    s_axis_tuser  <= cur_word.op;
                    s_axis_tvalid <= 1'b1;
                    gap = $urandom_range(0, gap_max);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                dim_m = cfg_data;
                cfg_valid <= 1'b0;
                dim_done++;
            end
            else if (!cfg_valid && dim_req_q.size() > 0)
            begin
                cfg_data  <= DIM_W'(dim_req_q.pop_front());
                cfg_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_r;
        int      w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (solution_q.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
            else
            begin
                exp_r = solution_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.val)
                    report_mismatch($sformatf("value_res %h, expected %h",
                                              m_axis_tdata[31:0], exp_r.val));
                if (m_axis_tdata[33:32] !== exp_r.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[33:32], exp_r.st));
            end
            w = $urandom_range(0, stall_max);
            stall = w;
            m_axis_tready <= (w == 0);
        end
        else if (stall > 0)
        begin
            stall = stall - 1;
            m_axis_tready <= (stall == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus: shadows of what has been loaded, so that no solve or read
    // touches an entry that was never written.
    // ------------------------------------------------------------------
    bit  ld_col[NDIM+1];
    bit  ld_ent[NNZ];
    bit  ld_diag[NDIM];
    bit  ld_sub[NDIM];
    bit  ld_perm[NDIM];
    bit  ld_rhs[NDIM];
    int  sh_col[NDIM+1];
    int  sh_perm[NDIM];
    int  gen_dim = 1;
    int  rand_words = 0;

    function automatic int sat_ptr(int p);
        return (p > NNZ) ? NNZ : p;
    endfunction

    function automatic logic [31:0] rand_value(int span);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    task automatic enqueue_word(op_t op, int idx, int row, int ptr, logic [31:0] val,
                                bit counted = 1'b1);
        word_t w;
        w.op  = op;
        w.idx = idx;
        w.row = row;
        w.ptr = ptr;
        w.val = val;
        case (op)
            OP_COL_START:
                if (idx <= NDIM)
                begin
                    ld_col[idx] = 1'b1;
                    sh_col[idx] = ptr;
                end
            OP_L_ENTRY: ld_ent[idx] = 1'b1;
            OP_D_DIAG:  if (idx < NDIM) ld_diag[idx] = 1'b1;
            OP_D_SUB:   if (idx < NDIM) ld_sub[idx] = 1'b1;
            OP_PERM:
                if (idx < NDIM)
                begin
                    ld_perm[idx] = 1'b1;
                    sh_perm[idx] = row;
                end
            OP_RHS:     if (idx < NDIM) ld_rhs[idx] = 1'b1;
            default: ;
        endcase
        pending_q.push_back(w);
        words_queued++;
        if (counted)
            rand_words++;
    endtask

    // Loads whatever a solve of the current order would read but is unwritten, then queues the solve.
    task automatic issue_solve();
        int n;
        int s;
        n = (gen_dim > NDIM) ? NDIM : gen_dim;
        for (int i = 0; i <= n; i++)
            if (!ld_col[i])
                enqueue_word(OP_COL_START, i, 0, (i == 0) ? 0 : sat_ptr(sh_col[i-1]),
                             '0, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            if (!ld_perm[i])
                enqueue_word(OP_PERM, i, i, 0, '0, 1'b0);
            if (!ld_diag[i])
                enqueue_word(OP_D_DIAG, i, 0, 0,
                             32'($urandom_range(32'h8000, 32'h30000)), 1'b0);
            if (!ld_sub[i])
                enqueue_word(OP_D_SUB, i, 0, 0, '0, 1'b0);
        end
        for (int i = 0; i < n; i++)
        begin
            s = sh_perm[i];
            if (s < n && !ld_rhs[s])
                enqueue_word(OP_RHS, s, 0, 0, rand_value(32'h40000), 1'b0);
        end
        for (int c = 0; c < n; c++)
            for (int j = sat_ptr(sh_col[c]); j < sat_ptr(sh_col[c+1]); j++)
                if (!ld_ent[j])
                    enqueue_word(OP_L_ENTRY, j, $urandom_range(0, 1023), 0,
                                 rand_value(32'h8000), 1'b0);
        enqueue_word(OP_SOLVE, 0, 0, 0, '0);
    endtask

    task automatic issue_reads(int count, int span);
        int idx;
        repeat (count)
        begin
            idx = $urandom_range(0, span - 1);
            if ($urandom_range(0, 4) == 0 || !ld_rhs[idx])
                idx = $urandom_range(NDIM, 16383);
            enqueue_word(OP_READ, idx, $urandom_range(0, 1023), $urandom_range(0, 32767),
                         $urandom);
        end
    endtask

    task automatic wait_quiet();
        while (words_sent != words_queued || solution_q.size() != 0)
            @(posedge clk);
        // Loads have no result word, so leave time for the last one to retire.
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dim(int v);
        wait_quiet();
        gen_dim = v;
        dim_writes++;
        dim_req_q.push_back(v);
        while (dim_done != dim_writes)
            @(posedge clk);
    endtask

    task automatic random_phase();
        int n;
        int p;
        int cnt;
        int row;
        int perm_a[$];
        gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
        stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        write_dim(n);
        if ($urandom_range(0, 9) != 0)
        begin
            p = $urandom_range(0, 40);
            enqueue_word(OP_COL_START, 0, 0, p, '0);
            for (int c = 0; c < n; c++)
            begin
                cnt = $urandom_range(0, 3);
                for (int k = 0; k < cnt; k++)
                begin
                    if ($urandom_range(0, 7) == 0 || c + 1 >= n)
                        row = $urandom_range(0, 1023);
                    else
                        row = $urandom_range(c + 1, n - 1);
                    enqueue_word(OP_L_ENTRY, p + k, row, 0, rand_value(32'h8000));
                end
                p += cnt;
                enqueue_word(OP_COL_START, c + 1, 0, p, '0);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                enqueue_word(OP_D_DIAG, i, 0, 0, '0);
            else if ($urandom_range(0, 19) == 0)
                enqueue_word(OP_D_DIAG, i, 0, 0, rand_value(32'h30000));
            else
                enqueue_word(OP_D_DIAG, i, 0, 0, $urandom_range(0, 1) ?
                             32'($urandom_range(32'h8000, 32'h30000)) :
                             32'(-$signed($urandom_range(32'h8000, 32'h30000))));
            enqueue_word(OP_D_SUB, i, 0, 0,
                         ($urandom_range(0, 3) == 0) ? rand_value(32'h10000) : 32'd0);
        end
        for (int i = 0; i < n; i++)
            perm_a.push_back(i);
        perm_a.shuffle();
        if ($urandom_range(0, 5) == 0)
            perm_a[$urandom_range(0, n - 1)] = $urandom_range(0, 1023);
        for (int i = 0; i < n; i++)
            enqueue_word(OP_PERM, i, perm_a[i], 0, '0);
        for (int i = 0; i < n; i++)
            enqueue_word(OP_RHS, i, 0, 0, rand_value(32'h40000));
        if ($urandom_range(0, 2) == 0)
        begin
            // Loads aimed past the end of their store are dropped by the block.
            enqueue_word(op_t'($urandom_range(OP_D_DIAG, OP_RHS)),
                         $urandom_range(NDIM, 16383), $urandom_range(0, 1023),
                         $urandom_range(0, 32767), $urandom, 1'b0);
            enqueue_word(OP_COL_START, $urandom_range(NDIM + 1, 16383), 0,
                         $urandom_range(0, 32767), $urandom, 1'b0);
        end
        issue_solve();
        issue_reads($urandom_range(1, 4), n);
        if ($urandom_range(0, 2) == 0)
        begin
            issue_solve();
            issue_reads($urandom_range(1, 3), n);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Order one: saturated and empty columns, a zero pivot with a right-hand side of each sign.
        write_dim(1);
        enqueue_word(OP_COL_START, 0, 0, 20000, '0);
        enqueue_word(OP_COL_START, 1, 0, 32767, '0);
        enqueue_word(OP_PERM, 0, 0, 0, '0);
        enqueue_word(OP_D_DIAG, 0, 0, 0, 32'h0);
        enqueue_word(OP_D_SUB, 0, 0, 0, 32'h8000_0000);
        enqueue_word(OP_RHS, 0, 0, 0, 32'h7FFF_FFFF);
        issue_solve();
        issue_reads(1, 1);
        enqueue_word(OP_RHS, 0, 0, 0, 32'h8000_0000);
        issue_solve();
        issue_reads(1, 1);
        // Quotient overflow: one over the smallest step.
        enqueue_word(OP_D_DIAG, 0, 0, 0, 32'h1);
        enqueue_word(OP_RHS, 0, 0, 0, 32'h0001_0000);
        issue_solve();
        // Last entry slot, with a row beyond the order.
        enqueue_word(OP_L_ENTRY, NNZ - 1, 1023, 0, 32'h7FFF_FFFF);
        enqueue_word(OP_COL_START, 0, 0, NNZ - 1, '0);
        enqueue_word(OP_COL_START, 1, 0, NNZ, '0);
        issue_solve();
        // Permutation source beyond the order.
        enqueue_word(OP_PERM, 0, 1023, 0, '0);
        issue_solve();
        enqueue_word(OP_READ, 0, 0, 0, '0);
        enqueue_word(OP_READ, 16383, 1023, 32767, 32'hFFFF_FFFF);
        enqueue_word(OP_READ, NDIM, 0, 0, '0);
        enqueue_word(OP_COL_START, NDIM + 1, 0, 5, '0, 1'b0);
        enqueue_word(OP_D_SUB, 16383, 0, 0, 32'h1234_5678, 1'b0);
        enqueue_word(OP_PERM, NDIM, 7, 0, '0, 1'b0);

        // Order zero: the solve does nothing.
        write_dim(0);
        enqueue_word(OP_SOLVE, 0, 0, 0, '0);
        enqueue_word(OP_READ, 0, 0, 0, '0);

        // Singular 2x2 block.
        write_dim(2);
        for (int i = 0; i <= 2; i++)
            enqueue_word(OP_COL_START, i, 0, 0, '0);
        enqueue_word(OP_PERM, 0, 1, 0, '0);
        enqueue_word(OP_PERM, 1, 0, 0, '0);
        enqueue_word(OP_D_DIAG, 0, 0, 0, 32'h0001_0000);
        enqueue_word(OP_D_DIAG, 1, 0, 0, 32'h0001_0000);
        enqueue_word(OP_D_SUB, 0, 0, 0, 32'h0001_0000);
        enqueue_word(OP_RHS, 0, 0, 0, 32'h0002_0000);
        enqueue_word(OP_RHS, 1, 0, 0, 32'hFFFF_0000);
        issue_solve();
        issue_reads(2, 2);

        // Largest order, then a register value beyond it.
        gap_max = 0;
        write_dim(NDIM);
        issue_solve();
        issue_reads(3, NDIM);
        write_dim(2047);
        gap_max = 8;
        issue_solve();
        issue_reads(3, NDIM);

        rand_words = 0;
        while (rand_words < 450)
            random_phase();

        wait_quiet();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[permuted_ldlt_block_solve_unit] OK");
        else
            $display("[permuted_ldlt_block_solve_unit] ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("[permuted_ldlt_block_solve_unit] ERROR");
        $finish;
    end

endmodule
